// ----- hw/rtl/sct_pkg.sv -----
// ----------------------------------------------------------------------------
// sct_pkg
// Types and character constants shared by the shell command tokeniser.
// ----------------------------------------------------------------------------
package sct_pkg;

    typedef enum logic [1:0] {
        MODE_BETWEEN = 2'd0,
        MODE_WORD    = 2'd1,
        MODE_QUOTE   = 2'd2
    } lex_mode_t;

    typedef enum logic [1:0] {
        PHASE_NONE         = 2'd0,
        PHASE_AFTER_LTLT   = 2'd1,
        PHASE_NEED_OPERAND = 2'd2
    } lt_phase_t;

    typedef logic [2:0] status_t;

    localparam status_t STATUS_OK        = 3'd0;
    localparam status_t STATUS_UNMATCHED = 3'd1;
    localparam status_t STATUS_UNEXP_OP  = 3'd2;
    localparam status_t STATUS_TRAIL_OP  = 3'd3;
    localparam status_t STATUS_OVERFLOW  = 3'd4;

    localparam logic [7:0] CH_AMP    = 8'h26;
    localparam logic [7:0] CH_PIPE   = 8'h7C;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       token_start;
        logic [7:0] token_index;
        logic       is_status;
        status_t    status;
        logic       last;
    } sct_item_t;

    // Request from the lexer into the result queue.
    typedef struct packed {
        logic [1:0] count;
        sct_item_t  item0;
        sct_item_t  item1;
    } sct_push_t;

endpackage

// ----- hw/rtl/sct_out_fifo.sv -----
// ----------------------------------------------------------------------------
// sct_out_fifo
// Four-entry result queue: takes up to two items per cycle, gives one while pop is high.
// ----------------------------------------------------------------------------
module sct_out_fifo (
    input  logic               aclk,
    input  logic               aresetn,
    input  sct_pkg::sct_push_t push,
    input  logic               pop,
    output sct_pkg::sct_item_t head_item,
    output logic               head_valid,
    output logic               room_for_two
);
    import sct_pkg::*;

    sct_item_t  mem_reg [4];
    logic [1:0] wr_ptr_reg;
    logic [1:0] wr_ptr_next;
    logic [1:0] rd_ptr_reg;
    logic [1:0] rd_ptr_next;
    logic [2:0] count_reg;
    logic [2:0] count_next;
    logic       do_pop;

    assign head_item    = mem_reg[rd_ptr_reg];
    assign head_valid   = (count_reg != 3'd0);
    assign room_for_two = (count_reg <= 3'd2);
    assign do_pop       = pop && head_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg + 2'(push.count);
        rd_ptr_next = rd_ptr_reg + 2'(do_pop);
        count_next  = count_reg + 3'(push.count) - 3'(do_pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push.count != 2'd0) begin
            mem_reg[wr_ptr_reg] <= push.item0;
        end
        if (push.count == 2'd2) begin
            mem_reg[wr_ptr_reg + 2'd1] <= push.item1;
        end
    end

endmodule

// ----- hw/rtl/shell_command_tokenizer_core.sv -----
// ----------------------------------------------------------------------------
// shell_command_tokenizer_core
// Streaming lexer that splits a shell command line into tokens.
// ----------------------------------------------------------------------------
// One character request is taken per clock cycle while s_ready is high. The
// lexer decides a character one request late, once the following character is
// visible, and writes up to two result items per request into a four-entry
// result queue that drains at one item per cycle; s_ready is low while that
// queue holds three or more items, so the rate is one request per cycle whenever
// the consumer keeps m_ready high. An end request flushes the held character and
// appends the status item, which carries last and the first error of the line.
module shell_command_tokenizer_core #(
    parameter int MAX_TOKENS = 256
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_ch,
    input  logic       s_is_end,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_byte,
    output logic       m_token_start,
    output logic [7:0] m_token_index,
    output logic       m_is_status,
    output logic [2:0] m_status,
    output logic       m_last
);
    import sct_pkg::*;

    // The counter is kept at least eight bits wide so that the token index
    // can always be taken from its low byte.
    localparam int TcW = ($clog2(MAX_TOKENS + 2) > 8) ? $clog2(MAX_TOKENS + 2) : 8;
    localparam logic [TcW-1:0] TcMax = TcW'(MAX_TOKENS);

    lex_mode_t      mode_reg, mode_next;
    logic           quote_kind_reg, quote_kind_next;
    logic [7:0]     held_byte_reg, held_byte_next;
    logic           held_valid_reg, held_valid_next;
    logic [TcW-1:0] tc_reg, tc_next;
    logic           prev_op_reg, prev_op_next;
    logic           no_tok_reg, no_tok_next;
    lt_phase_t      phase_reg, phase_next;
    status_t        err_reg, err_next;

    sct_push_t push;
    sct_item_t head_item;
    logic      head_valid;
    logic      room_for_two;
    logic      accept;

    assign s_ready = room_for_two;
    assign accept  = s_valid && room_for_two;

    always_comb begin
        logic       run;
        logic       has_next;
        logic [7:0] c0;
        logic [7:0] c1;
        logic [1:0] op;
        logic       third_lt;
        logic       blank;
        logic       consumed;
        logic       e0_v;
        logic       e0_start;
        logic       e1_v;
        logic       emit_ok;
        logic [TcW-1:0] idx;
        sct_item_t  b0;
        sct_item_t  b1;
        sct_item_t  st;

        mode_next       = mode_reg;
        quote_kind_next = quote_kind_reg;
        held_byte_next  = held_byte_reg;
        held_valid_next = held_valid_reg;
        tc_next         = tc_reg;
        prev_op_next    = prev_op_reg;
        no_tok_next     = no_tok_reg;
        phase_next      = phase_reg;
        err_next        = err_reg;

        run      = held_valid_reg;
        has_next = !s_is_end;
        c0       = held_byte_reg;
        c1       = s_ch;
        op       = 2'd0;
        third_lt = 1'b0;
        consumed = 1'b0;
        e0_v     = 1'b0;
        e0_start = 1'b0;
        e1_v     = 1'b0;
        blank    = (c0 == CH_SPACE) || (c0 >= CH_TAB && c0 <= CH_CR);

        if (has_next && c0 == c1 &&
            (c0 == CH_AMP || c0 == CH_PIPE || c0 == CH_GT || c0 == CH_LT)) begin
            op = 2'd2;
        end else if (c0 == CH_PIPE || c0 == CH_GT || c0 == CH_LT) begin
            op = 2'd1;
        end

        if (run) begin
            if (mode_reg == MODE_QUOTE) begin
                e0_v = 1'b1;
                if (c0 == (quote_kind_reg ? CH_SQUOTE : CH_DQUOTE)) begin
                    mode_next = MODE_BETWEEN;
                end
            end else begin
                third_lt = (phase_reg == PHASE_AFTER_LTLT) && (op == 2'd1) && (c0 == CH_LT);
                if (phase_reg == PHASE_AFTER_LTLT && !third_lt) begin
                    phase_next = PHASE_NONE;
                end
                if (blank) begin
                    mode_next = MODE_BETWEEN;
                end else if (op != 2'd0) begin
                    if (third_lt) begin
                        phase_next   = PHASE_NEED_OPERAND;
                        prev_op_next = 1'b0;
                    end else begin
                        if (phase_next == PHASE_NEED_OPERAND || prev_op_reg || no_tok_reg) begin
                            if (err_next == STATUS_OK) begin
                                err_next = STATUS_UNEXP_OP;
                            end
                        end
                        prev_op_next = 1'b1;
                        phase_next   = (op == 2'd2 && c0 == CH_LT) ? PHASE_AFTER_LTLT
                                                                   : PHASE_NONE;
                    end
                    no_tok_next = 1'b0;
                    if (tc_reg < TcMax) begin
                        tc_next = tc_reg + TcW'(1);
                    end else begin
                        tc_next = TcMax + TcW'(1);
                        if (err_next == STATUS_OK) begin
                            err_next = STATUS_OVERFLOW;
                        end
                    end
                    e0_v      = 1'b1;
                    e0_start  = 1'b1;
                    e1_v      = (op == 2'd2);
                    consumed  = (op == 2'd2);
                    mode_next = MODE_BETWEEN;
                end else if (mode_reg == MODE_WORD) begin
                    e0_v = 1'b1;
                end else begin
                    phase_next   = PHASE_NONE;
                    prev_op_next = 1'b0;
                    no_tok_next  = 1'b0;
                    if (tc_reg < TcMax) begin
                        tc_next = tc_reg + TcW'(1);
                    end else begin
                        tc_next = TcMax + TcW'(1);
                        if (err_next == STATUS_OK) begin
                            err_next = STATUS_OVERFLOW;
                        end
                    end
                    if (c0 == CH_DQUOTE || c0 == CH_SQUOTE) begin
                        mode_next       = MODE_QUOTE;
                        quote_kind_next = (c0 == CH_SQUOTE);
                    end else begin
                        mode_next = MODE_WORD;
                    end
                    e0_v     = 1'b1;
                    e0_start = 1'b1;
                end
            end
        end

        // Bytes of tokens beyond the limit are dropped.
        emit_ok = (tc_next != '0) && (tc_next <= TcMax);
        e0_v    = e0_v && emit_ok;
        e1_v    = e1_v && emit_ok;
        idx     = tc_next - TcW'(1);

        b0             = '0;
        b0.out_byte    = c0;
        b0.token_start = e0_start;
        b0.token_index = idx[7:0];
        b1             = '0;
        b1.out_byte    = c1;
        b1.token_index = idx[7:0];

        if (s_is_end) begin
            if (mode_next == MODE_QUOTE && err_next == STATUS_OK) begin
                err_next = STATUS_UNMATCHED;
            end
            if (phase_next == PHASE_NEED_OPERAND) begin
                if (err_next == STATUS_OK) begin
                    err_next = STATUS_UNEXP_OP;
                end
            end else if (prev_op_next && err_next == STATUS_OK) begin
                err_next = STATUS_TRAIL_OP;
            end
        end

        st           = '0;
        st.is_status = 1'b1;
        st.status    = err_next;
        st.last      = 1'b1;

        push.count = 2'(e0_v) + 2'(e1_v) + 2'(s_is_end);
        push.item0 = e0_v ? b0 : st;
        push.item1 = e1_v ? b1 : st;
        if (!accept) begin
            push.count = 2'd0;
        end

        if (s_is_end) begin
            mode_next       = MODE_BETWEEN;
            quote_kind_next = 1'b0;
            held_byte_next  = '0;
            held_valid_next = 1'b0;
            tc_next         = '0;
            prev_op_next    = 1'b0;
            no_tok_next     = 1'b1;
            phase_next      = PHASE_NONE;
            err_next        = STATUS_OK;
        end else if (!held_valid_reg) begin
            held_byte_next  = s_ch;
            held_valid_next = 1'b1;
        end else if (consumed) begin
            held_byte_next  = '0;
            held_valid_next = 1'b0;
        end else begin
            held_byte_next = s_ch;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg       <= MODE_BETWEEN;
            quote_kind_reg <= 1'b0;
            held_byte_reg  <= '0;
            held_valid_reg <= 1'b0;
            tc_reg         <= '0;
            prev_op_reg    <= 1'b0;
            no_tok_reg     <= 1'b1;
            phase_reg      <= PHASE_NONE;
            err_reg        <= STATUS_OK;
        end else if (accept) begin
            mode_reg       <= mode_next;
            quote_kind_reg <= quote_kind_next;
            held_byte_reg  <= held_byte_next;
            held_valid_reg <= held_valid_next;
            tc_reg         <= tc_next;
            prev_op_reg    <= prev_op_next;
            no_tok_reg     <= no_tok_next;
            phase_reg      <= phase_next;
            err_reg        <= err_next;
        end
    end

    sct_out_fifo u_out_fifo (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .push         (push),
        .pop          (m_ready),
        .head_item    (head_item),
        .head_valid   (head_valid),
        .room_for_two (room_for_two)
    );

    assign m_valid       = head_valid;
    assign m_out_byte    = head_item.out_byte;
    assign m_token_start = head_item.token_start;
    assign m_token_index = head_item.token_index;
    assign m_is_status   = head_item.is_status;
    assign m_status      = head_item.status;
    assign m_last        = head_item.last;

endmodule

// ----- test/sct_token_checker.sv -----
// ----------------------------------------------------------------------------
// sct_token_checker
// Watches both channels of the shell command tokeniser, predicts the token
// bytes and the status item of every line, and compares what comes out.
// ----------------------------------------------------------------------------
module sct_token_checker #(
    parameter int MAX_TOKENS = 256
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    input  logic       s_ready,
    input  logic [7:0] s_ch,
    input  logic       s_is_end,
    input  logic       m_valid,
    input  logic       m_ready,
    input  logic [7:0] m_out_byte,
    input  logic       m_token_start,
    input  logic [7:0] m_token_index,
    input  logic       m_is_status,
    input  logic [2:0] m_status,
    input  logic       m_last,
    output int         mismatches,
    output int         pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import sct_pkg::*;

    // Lexer state of the line being predicted.
    lex_mode_t   mode;
    logic        quote_sq;
    logic [7:0]  held_ch;
    logic        held_ok;
    int unsigned n_tokens;
    logic        after_op;
    logic        line_empty;
    lt_phase_t   lt_phase;
    status_t     first_err;

    sct_item_t   token_q[$];
    sct_item_t   want;

    function automatic void clear_line();
        mode       = MODE_BETWEEN;
        quote_sq   = 1'b0;
        held_ch    = 8'h00;
        held_ok    = 1'b0;
        n_tokens   = 0;
        after_op   = 1'b0;
        line_empty = 1'b1;
        lt_phase   = PHASE_NONE;
        first_err  = STATUS_OK;
    endfunction

    function automatic void note_error(status_t code);
        if (first_err == STATUS_OK) begin
            first_err = code;
        end
    endfunction

    function automatic logic is_space_char(logic [7:0] c);
        return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic int oper_len(logic [7:0] c0, logic has_next, logic [7:0] c1);
        if (has_next && c0 == c1 &&
            (c0 == CH_AMP || c0 == CH_PIPE || c0 == CH_GT || c0 == CH_LT)) begin
            return 2;
        end
        if (c0 == CH_PIPE || c0 == CH_GT || c0 == CH_LT) begin
            return 1;
        end
        return 0;
    endfunction

    // Bytes of tokens beyond the limit are swallowed.
    function automatic void push_byte(logic [7:0] b, logic start);
        sct_item_t it;
        if (n_tokens == 0 || n_tokens > MAX_TOKENS) begin
            return;
        end
        it             = '0;
        it.out_byte    = b;
        it.token_start = start;
        it.token_index = 8'(n_tokens - 1);
        token_q.push_back(it);
    endfunction

    function automatic void begin_token();
        if (n_tokens < MAX_TOKENS) begin
            n_tokens++;
        end else begin
            n_tokens = MAX_TOKENS + 1;
            note_error(STATUS_OVERFLOW);
        end
    endfunction

    // Decides the held character c0 with c1 visible; true when c1 was consumed.
    function automatic logic lex_char(logic [7:0] c0, logic has_next, logic [7:0] c1);
        int   op;
        logic third_lt;
        if (mode == MODE_QUOTE) begin
            push_byte(c0, 1'b0);
            if (c0 == (quote_sq ? CH_SQUOTE : CH_DQUOTE)) begin
                mode = MODE_BETWEEN;
            end
            return 1'b0;
        end
        op       = oper_len(c0, has_next, c1);
        third_lt = lt_phase == PHASE_AFTER_LTLT && op == 1 && c0 == CH_LT;
        if (lt_phase == PHASE_AFTER_LTLT && !third_lt) begin
            lt_phase = PHASE_NONE;
        end
        if (is_space_char(c0)) begin
            mode = MODE_BETWEEN;
            return 1'b0;
        end
        if (op != 0) begin
            if (third_lt) begin
                lt_phase = PHASE_NEED_OPERAND;
                after_op = 1'b0;
            end else begin
                if (lt_phase == PHASE_NEED_OPERAND || after_op || line_empty) begin
                    note_error(STATUS_UNEXP_OP);
                end
                after_op = 1'b1;
                lt_phase = (op == 2 && c0 == CH_LT) ? PHASE_AFTER_LTLT : PHASE_NONE;
            end
            line_empty = 1'b0;
            begin_token();
            push_byte(c0, 1'b1);
            if (op == 2) begin
                push_byte(c1, 1'b0);
            end
            mode = MODE_BETWEEN;
            return op == 2;
        end
        if (mode == MODE_WORD) begin
            push_byte(c0, 1'b0);
            return 1'b0;
        end
        lt_phase   = PHASE_NONE;
        after_op   = 1'b0;
        line_empty = 1'b0;
        begin_token();
        if (c0 == CH_DQUOTE || c0 == CH_SQUOTE) begin
            mode     = MODE_QUOTE;
            quote_sq = c0 == CH_SQUOTE;
        end else begin
            mode = MODE_WORD;
        end
        push_byte(c0, 1'b1);
        return 1'b0;
    endfunction

    function automatic void take_request(logic [7:0] c, logic is_end);
        sct_item_t st;
        if (is_end) begin
            if (held_ok) begin
                void'(lex_char(held_ch, 1'b0, 8'h00));
            end
            held_ok = 1'b0;
            if (mode == MODE_QUOTE) begin
                note_error(STATUS_UNMATCHED);
            end
            if (lt_phase == PHASE_NEED_OPERAND) begin
                note_error(STATUS_UNEXP_OP);
            end else if (after_op) begin
                note_error(STATUS_TRAIL_OP);
            end
            st           = '0;
            st.is_status = 1'b1;
            st.status    = first_err;
            st.last      = 1'b1;
            token_q.push_back(st);
            clear_line();
        end else if (!held_ok) begin
            held_ch = c;
            held_ok = 1'b1;
        end else if (lex_char(held_ch, 1'b1, c)) begin
            held_ch = 8'h00;
            held_ok = 1'b0;
        end else begin
            held_ch = c;
        end
    endfunction

    function automatic void cmp_field(string name, logic [7:0] exp_v, logic [7:0] act_v);
        if (act_v !== exp_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            mismatches++;
        end
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            clear_line();
            token_q.delete();
        end else begin
            if (s_valid && s_ready) begin
                take_request(s_ch, s_is_end);
            end
            if (m_valid && m_ready) begin
                if (token_q.size() == 0) begin
                    $error("unexpected result: byte %0d, status flag %0b",
                           m_out_byte, m_is_status);
                    mismatches++;
                end else begin
                    want = token_q.pop_front();
                    cmp_field("out_byte", want.out_byte, m_out_byte);
                    cmp_field("token_start", 8'(want.token_start), 8'(m_token_start));
                    cmp_field("token_index", want.token_index, m_token_index);
                    cmp_field("is_status", 8'(want.is_status), 8'(m_is_status));
                    cmp_field("status", 8'(want.status), 8'(m_status));
                    cmp_field("last", 8'(want.last), 8'(m_last));
                end
            end
        end
        pending = token_q.size();
    end

endmodule

// ----- test/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Drives command lines into the shell command tokeniser: a few directed lines,
// then random commands, noise, a line at the token limit and one past it, with
// bursty requests and a stalling consumer. The checker beside the block does the comparison.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sct_pkg::*;

    localparam int MAX_TOK    = 256;
    localparam int RAND_ITEMS = 1500;
    localparam int IDLE_LIMIT = 2000;

    logic       aclk     = 1'b0;
    logic       aresetn  = 1'b0;
    logic       s_valid  = 1'b0;
    logic       s_ready;
    logic [7:0] s_ch     = 8'h00;
    logic       s_is_end = 1'b0;
    logic       m_valid;
    logic       m_ready  = 1'b0;
    logic [7:0] m_out_byte;
    logic       m_token_start;
    logic [7:0] m_token_index;
    logic       m_is_status;
    logic [2:0] m_status;
    logic       m_last;

    int         mismatches;
    int         pending;
    int         burst_left  = 0;
    int         rx_hold     = 0;
    int         idle_cycles = 0;
    int         n_sent      = 0;
    int         line_no     = 0;
    logic       fast_line   = 1'b0;
    logic [7:0] line_buf[$];

    always #4 aclk = ~aclk;

    shell_command_tokenizer_core #(
        .MAX_TOKENS(MAX_TOK)
    ) u_top (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_ch         (s_ch),
        .s_is_end     (s_is_end),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_byte   (m_out_byte),
        .m_token_start(m_token_start),
        .m_token_index(m_token_index),
        .m_is_status  (m_is_status),
        .m_status     (m_status),
        .m_last       (m_last)
    );

    sct_token_checker #(
        .MAX_TOKENS(MAX_TOK)
    ) u_chk (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_ch         (s_ch),
        .s_is_end     (s_is_end),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_byte   (m_out_byte),
        .m_token_start(m_token_start),
        .m_token_index(m_token_index),
        .m_is_status  (m_is_status),
        .m_status     (m_status),
        .m_last       (m_last),
        .mismatches   (mismatches),
        .pending      (pending)
    );

    // Consumer: always ready on fast lines; else holds each ready level for a random stretch, now and then a long one.
    always @(negedge aclk) begin
        if (fast_line) begin
            m_ready <= 1'b1;
        end else if (rx_hold > 0) begin
            rx_hold--;
        end else begin
            m_ready <= $urandom_range(0, 2) != 0;
            rx_hold = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 40)
                                                   : $urandom_range(0, 6);
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("** shell_command_tokenizer_core: FAILED **");
                $finish;
            end
        end
    end

    task automatic send_req(input logic [7:0] c, input logic is_end);
        int gap;
        if (burst_left == 0) begin
            gap = fast_line ? 0 : $urandom_range(0, 5);
            if (!fast_line && $urandom_range(0, 9) == 0) begin
                gap = $urandom_range(10, 30);
            end
            if (gap > 0) begin
                @(negedge aclk);
                s_valid <= 1'b0;
                repeat (gap - 1) @(negedge aclk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        @(negedge aclk);
        s_valid  <= 1'b1;
        s_ch     <= c;
        s_is_end <= is_end;
        do @(posedge aclk); while (!s_ready);
        n_sent++;
    endtask

    // Sends the buffered line, closes it with an end request and empties the buffer.
    task automatic flush_line();
        foreach (line_buf[i]) begin
            send_req(line_buf[i], 1'b0);
        end
        send_req(8'($urandom), 1'b1);
        line_buf.delete();
        fast_line = $urandom_range(0, 4) == 0;
    endtask

    function automatic void add_text(string s);
        for (int i = 0; i < s.len(); i++) begin
            line_buf.push_back(s[i]);
        end
    endfunction

    function automatic logic [7:0] word_char();
        logic [7:0] c;
        do begin
            c = 8'($urandom);
        end while (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR) || c == CH_DQUOTE ||
                   c == CH_SQUOTE || c == CH_PIPE || c == CH_GT || c == CH_LT);
        return c;
    endfunction

    function automatic void add_gap(int max_n);
        int n;
        int k;
        n = $urandom_range(0, max_n);
        for (int i = 0; i < n; i++) begin
            k = $urandom_range(0, 6);
            line_buf.push_back(k == 6 ? CH_SPACE : 8'(CH_TAB + k));
        end
    endfunction

    function automatic void add_op();
        case ($urandom_range(0, 7))
            0: begin line_buf.push_back(CH_AMP);  line_buf.push_back(CH_AMP);  end
            1: begin line_buf.push_back(CH_PIPE); line_buf.push_back(CH_PIPE); end
            2: begin line_buf.push_back(CH_GT);   line_buf.push_back(CH_GT);   end
            3: begin line_buf.push_back(CH_LT);   line_buf.push_back(CH_LT);   end
            4: line_buf.push_back(CH_PIPE);
            5: line_buf.push_back(CH_GT);
            6: line_buf.push_back(CH_LT);
            default: begin
                line_buf.push_back(CH_LT);
                line_buf.push_back(CH_LT);
                line_buf.push_back(CH_LT);
            end
        endcase
    endfunction

    function automatic void add_operand();
        logic [7:0] q;
        logic [7:0] c;
        int         n;
        if ($urandom_range(0, 3) == 0) begin
            q = $urandom_range(0, 1) ? CH_SQUOTE : CH_DQUOTE;
            line_buf.push_back(q);
            n = $urandom_range(0, 5);
            for (int i = 0; i < n; i++) begin
                do c = 8'($urandom); while (c == q);
                line_buf.push_back(c);
            end
            // An occasional quote is left open and runs to the end of the line.
            if ($urandom_range(0, 14) != 0) begin
                line_buf.push_back(q);
            end
        end else begin
            n = $urandom_range(1, 5);
            for (int i = 0; i < n; i++) begin
                line_buf.push_back(word_char());
            end
        end
    endfunction

    function automatic void make_command();
        int n_args;
        n_args = $urandom_range(1, 5);
        if ($urandom_range(0, 9) == 0) begin
            add_op();
        end
        for (int i = 0; i < n_args; i++) begin
            add_gap(2);
            if (i > 0) begin
                add_op();
                if ($urandom_range(0, 11) == 0) begin
                    add_op();
                end
                add_gap(2);
            end
            add_operand();
        end
        if ($urandom_range(0, 9) == 0) begin
            add_op();
        end
        add_gap(2);
    endfunction

    function automatic void make_noise();
        int n;
        n = $urandom_range(0, 10);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 1)) begin
                line_buf.push_back(8'($urandom));
            end else begin
                case ($urandom_range(0, 7))
                    0: line_buf.push_back(CH_AMP);
                    1: line_buf.push_back(CH_PIPE);
                    2: line_buf.push_back(CH_GT);
                    3: line_buf.push_back(CH_LT);
                    4: line_buf.push_back(CH_DQUOTE);
                    5: line_buf.push_back(CH_SQUOTE);
                    6: line_buf.push_back(CH_SPACE);
                    default: line_buf.push_back(8'h61);
                endcase
            end
        end
    endfunction

    // One-character words and single operators in turn, so every character is a token.
    function automatic void make_token_run(int n_tok);
        for (int i = 0; i < n_tok; i++) begin
            if (i % 2 == 0) begin
                line_buf.push_back(word_char());
            end else begin
                case ($urandom_range(0, 2))
                    0: line_buf.push_back(CH_PIPE);
                    1: line_buf.push_back(CH_GT);
                    default: line_buf.push_back(CH_LT);
                endcase
            end
        end
    endfunction

    initial begin
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        add_text("a&&b<<<'c d'|e");
        flush_line();
        add_text("|x<");
        flush_line();
        add_text("y<<<");
        flush_line();
        add_text("\"q");
        flush_line();
        flush_line();
        add_text("z>>|");
        line_buf.push_back(8'h00);
        flush_line();

        while (n_sent < RAND_ITEMS) begin
            line_no++;
            if (line_no == 30) begin
                make_token_run(MAX_TOK);
            end else if (line_no == 50) begin
                make_token_run(MAX_TOK + $urandom_range(1, 4));
            end else if ($urandom_range(0, 5) == 0) begin
                make_noise();
            end else begin
                make_command();
            end
            flush_line();
        end

        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (20) @(negedge aclk);
        if (mismatches == 0 && pending == 0 && !m_valid) begin
            $display("** shell_command_tokenizer_core: PASSED **");
        end else begin
            $display("** shell_command_tokenizer_core: FAILED **");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
hw/rtl/sct_pkg.sv
hw/rtl/sct_out_fifo.sv
hw/rtl/shell_command_tokenizer_core.sv
test/sct_token_checker.sv
test/tb.sv
